FILE: src/pkst_pkg.sv
// ---------------------------------------------------------------------------
// pkst_pkg: shared types and constants
// Slot count, event/result payloads and sequencer states.
// ---------------------------------------------------------------------------
package pkst_pkg;
	localparam int KEY_SLOTS = 32;
	localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CNT_W = $clog2(KEY_SLOTS + 1);
	localparam int ENT_W = 42;

	typedef struct packed {
		logic        key_pressed;
		logic [9:0]  keycode;
		logic [31:0] key_id;
		logic [7:0]  modifier_mask;
	} key_event_t;

	typedef struct packed {
		logic        release_found;
		logic        insert_dropped;
		logic [5:0]  entry_count;
		logic [31:0] newest_key;
	} key_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_SCAN,
		ST_NEXT,
		ST_DONE
	} pkst_state_t;
endpackage

FILE: src/pkst_ram.sv
// ---------------------------------------------------------------------------
// pkst_ram: generic single-port-write, single-read RAM
// Registered read.
// ---------------------------------------------------------------------------
module pkst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/pressed_key_set_tracker.sv
// ---------------------------------------------------------------------------
// pressed_key_set_tracker: sorted set of pressed keys
// Each pass reads the set entry by entry, ST_RD then ST_SCAN per entry, then
// ST_NEXT; an empty set goes from ST_RD straight to ST_NEXT. ST_DONE posts
// the result. A modifier removal pass may run before the event's own pass.
// A press on a full set ends after its read state.
// One event at a time; no new event is taken while a result waits in the
// output register, and the next one is accepted once the result is taken.
// Reset: a clearing pass zeroes all KEY_SLOTS RAM entries; no input is taken
// until it ends.
// ---------------------------------------------------------------------------
module pressed_key_set_tracker import pkst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  key_event_t  in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output key_result_t out_data
);
	// pass kinds
	localparam logic [1:0] P_MOD = 2'd0, P_REL = 2'd1, P_INS = 2'd2;

	pkst_state_t state_q;
	key_event_t  ev_q;
	logic [1:0]  pass_q;
	logic [9:0]  code_q;          // code removed in current pass
	logic [IDX_W-1:0] rd_q, wr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W:0]   rd_n;
	logic [31:0] latest_q;
	logic [7:0]  prevmod_q;
	logic [9:0]  lastcode_q;
	logic        hit_q, placed_q, drop_q;
	logic [ENT_W-1:0] carry_q;    // entry shifted toward the end on insert
	logic        ovalid_q;
	key_result_t odata_q;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [ENT_W-1:0] wdata, rdata;

	pkst_ram #(.WIDTH(ENT_W), .DEPTH(KEY_SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [31:0] r_id;
	logic [9:0]  r_code;
	logic        last_rd;
	assign r_id = rdata[41:10];
	assign r_code = rdata[9:0];
	assign rd_n = {1'b0, cnt_q} ;
	assign last_rd = ({1'b0, {(CNT_W-IDX_W){1'b0}}, rd_q} + 1'b1) >= rd_n;
	assign raddr = rd_q;
	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data = odata_q;

	always_comb begin
		we = 1'b0;
		waddr = wr_q;
		wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_SCAN: begin
				if (pass_q == P_INS) begin
					we = 1'b1;
					waddr = rd_q;
					if (!placed_q && r_id >= ev_q.key_id) begin
						wdata = {ev_q.key_id, ev_q.keycode};
					end else if (placed_q) begin
						wdata = carry_q;
					end else begin
						wdata = rdata;
					end
				end else begin
					we = (r_code != code_q);
					wdata = rdata;
				end
			end
			ST_NEXT: begin
				// append on insert: last carried entry or the new pair
				if (pass_q == P_INS) begin
					we = 1'b1;
					waddr = IDX_W'(cnt_q);
					wdata = placed_q ? carry_q : {ev_q.key_id, ev_q.keycode};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			latest_q <= '0;
			prevmod_q <= '0;
			lastcode_q <= '0;
			ovalid_q <= 1'b0;
			pass_q <= P_MOD;
			hit_q <= 1'b0;
			placed_q <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (wr_q == IDX_W'(KEY_SLOTS - 1)) begin
						wr_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						wr_q <= wr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						ev_q <= in_data;
						prevmod_q <= in_data.modifier_mask;
						rd_q <= '0;
						wr_q <= '0;
						hit_q <= 1'b0;
						placed_q <= 1'b0;
						drop_q <= 1'b0;
						if (in_data.modifier_mask != prevmod_q && lastcode_q != 10'd0) begin
							pass_q <= P_MOD;
							code_q <= lastcode_q;
						end else if (in_data.key_pressed) begin
							pass_q <= P_INS;
						end else begin
							pass_q <= P_REL;
							code_q <= in_data.keycode;
						end
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (pass_q == P_INS && cnt_q >= CNT_W'(KEY_SLOTS)) begin
						drop_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (cnt_q == '0) begin
						state_q <= ST_NEXT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pass_q == P_INS) begin
						if (!placed_q && r_id >= ev_q.key_id) begin
							placed_q <= 1'b1;
							carry_q <= rdata;
						end else if (placed_q) begin
							carry_q <= rdata;
						end
					end else if (r_code != code_q) begin
						wr_q <= wr_q + 1'b1;
					end else begin
						hit_q <= 1'b1;
					end
					if (last_rd) begin
						state_q <= ST_NEXT;
					end else begin
						rd_q <= rd_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_NEXT: begin
					if (pass_q == P_INS) begin
						cnt_q <= cnt_q + 1'b1;
						latest_q <= ev_q.key_id;
						state_q <= ST_DONE;
					end else begin
						// kept entries are packed at the front
						if (hit_q) begin
							cnt_q <= CNT_W'(wr_q);
						end
						latest_q <= '0;
						rd_q <= '0;
						if (pass_q == P_MOD && ev_q.key_pressed) begin
							pass_q <= P_INS;
							hit_q <= 1'b0;
							wr_q <= '0;
							state_q <= ST_RD;
						end else if (pass_q == P_MOD) begin
							pass_q <= P_REL;
							code_q <= ev_q.keycode;
							hit_q <= 1'b0;
							wr_q <= '0;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (ev_q.key_pressed) begin
						lastcode_q <= ev_q.keycode;
					end
					odata_q.release_found <= (pass_q == P_REL) && hit_q;
					odata_q.insert_dropped <= drop_q;
					odata_q.entry_count <= 6'(cnt_q);
					odata_q.newest_key <= latest_q;
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: tb/pkst_checker.sv
// ---------------------------------------------------------------------------
// pkst_checker: key-set result checker
// Watches both channels, keeps its own copy of the pressed-key set, predicts
// one result per accepted event and compares it with the returned results.
// ---------------------------------------------------------------------------
module pkst_checker import pkst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  key_event_t  in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  key_result_t out_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] set_ids [KEY_SLOTS];
	logic [9:0]  set_codes [KEY_SLOTS];
	int          set_len;
	logic [31:0] newest;
	logic [7:0]  prev_mods;
	logic [9:0]  last_code;
	key_result_t result_q [$];

	function automatic bit purge_code(logic [9:0] code);
		int keep;
		bit hit;
		keep = 0;
		hit = 0;
		for (int i = 0; i < set_len; i++) begin
			if (set_codes[i] == code) begin
				hit = 1;
			end else begin
				set_ids[keep] = set_ids[i];
				set_codes[keep] = set_codes[i];
				keep++;
			end
		end
		for (int i = keep; i < set_len; i++) begin
			set_ids[i] = '0;
			set_codes[i] = '0;
		end
		set_len = keep;
		newest = '0;
		return hit;
	endfunction

	function automatic key_result_t track_event(key_event_t ev);
		key_result_t r;
		int pos;
		r = '0;
		if (ev.modifier_mask != prev_mods && last_code != 0)
			void'(purge_code(last_code));
		prev_mods = ev.modifier_mask;
		if (ev.key_pressed) begin
			if (set_len >= KEY_SLOTS) begin
				r.insert_dropped = 1;
			end else begin
				pos = 0;
				while (pos < set_len && set_ids[pos] < ev.key_id) pos++;
				for (int j = set_len; j > pos; j--) begin
					set_ids[j] = set_ids[j-1];
					set_codes[j] = set_codes[j-1];
				end
				set_ids[pos] = ev.key_id;
				set_codes[pos] = ev.keycode;
				set_len++;
				newest = ev.key_id;
			end
			last_code = ev.keycode;
		end else begin
			r.release_found = purge_code(ev.keycode);
		end
		r.entry_count = 6'(set_len);
		r.newest_key = newest;
		return r;
	endfunction

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		key_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				set_ids[i] = '0;
				set_codes[i] = '0;
			end
			set_len = 0;
			newest = '0;
			prev_mods = '0;
			last_code = '0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", out_data);
				end else begin
					exp_r = result_q.pop_front();
					if (out_data.release_found !== exp_r.release_found ||
							out_data.insert_dropped !== exp_r.insert_dropped ||
							out_data.entry_count !== exp_r.entry_count ||
							out_data.newest_key !== exp_r.newest_key) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp found=%b drop=%b cnt=%0d key=%h, got found=%b drop=%b cnt=%0d key=%h",
								exp_r.release_found, exp_r.insert_dropped,
								exp_r.entry_count, exp_r.newest_key,
								out_data.release_found, out_data.insert_dropped,
								out_data.entry_count, out_data.newest_key);
					end
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(track_event(in_data));
		end
	end
endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: pressed-key set tracker testbench
// Drives directed and random key events with random idling and back-pressure;
// the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top import pkst_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	key_event_t  in_data = '0;
	logic        out_valid;
	logic        out_stall = 0;
	key_result_t out_data;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	bit          calm = 0;
	bit          hold_out = 0;
	logic [9:0]  code_pool [8];
	logic [7:0]  cur_mods = '0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	pressed_key_set_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	pkst_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		if (hold_out)
			out_stall <= 1;
		else
			out_stall <= !calm && ($urandom_range(99) < 6);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_event(bit pressed, logic [9:0] code, logic [31:0] id,
			logic [7:0] mods);
		key_event_t ev;
		ev.key_pressed = pressed;
		ev.keycode = code;
		ev.key_id = id;
		ev.modifier_mask = mods;
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= ev;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	task automatic random_event();
		int sel;
		logic [9:0] code;
		sel = $urandom_range(99);
		code = ($urandom_range(9) == 0) ? 10'($urandom) : code_pool[$urandom_range(7)];
		if ($urandom_range(9) == 0)
			cur_mods = 8'($urandom);
		if (sel < 8)
			send_event(1'($urandom), 10'($urandom), $urandom, 8'($urandom));
		else
			send_event(sel < 62, code,
				($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40)), cur_mods);
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			code_pool[i] = 10'($urandom_range(1, 1023));
		code_pool[0] = '0;
		code_pool[1] = 10'h3FF;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		calm = 1;
		send_event(0, 10'd5, 32'd0, 8'h00);
		send_event(1, 10'd0, 32'hFFFFFFFF, 8'h00);
		send_event(1, 10'h3FF, 32'd0, 8'h00);
		send_event(1, 10'd7, 32'd100, 8'h00);
		send_event(1, 10'd8, 32'd100, 8'h00);
		send_event(1, 10'd7, 32'd50, 8'h00);
		send_event(0, 10'd7, 32'd0, 8'h00);
		send_event(0, 10'd9, 32'd0, 8'h00);
		send_event(1, 10'd12, 32'd3, 8'h00);
		send_event(1, 10'd12, 32'd4, 8'hFF);
		send_event(1, 10'd0, 32'd6, 8'h01);
		send_event(0, 10'd0, 32'd0, 8'h01);
		for (int i = 0; i < 34; i++)
			send_event(1, 10'(i + 20), $urandom, 8'h01);
		send_event(0, 10'd25, 32'd0, 8'h01);
		calm = 0;
		drain();
		for (int i = 0; i < 400; i++)
			random_event();
		hold_out <= 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_out <= 0;
			end
			for (int i = 0; i < 20; i++)
				random_event();
		join
		drain();
		calm = 1;
		for (int i = 0; i < 150; i++)
			random_event();
		calm = 0;
		for (int i = 0; i < 250; i++)
			random_event();
		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
